FILE: hdl/mwe_pkg.sv
// shared types, constants and helpers of the meyer wavelet evaluator
`default_nettype none
package mwe_pkg;

	localparam int CORDIC_STEPS_DEF = 24;
	localparam int CORDIC_MAX       = 32;
	localparam int QUEUE_DEPTH      = 2;

	localparam int PW    = 24;   // point width
	localparam int TW    = 25;   // shifted point width
	localparam int AW    = 32;   // binary angle width
	localparam int XYW   = 33;   // cordic vector width, q30
	localparam int ZW    = 34;   // cordic residual angle width
	localparam int QB    = 34;   // quotient magnitude bits
	localparam int NMW   = 60;   // numerator magnitude width
	localparam int KW    = 30;   // width of 3/(4pi) in q32
	localparam int NUM_W = 90;   // scaled numerator width
	localparam int DEN_W = 81;   // scaled denominator width
	localparam int RW    = 32;   // result width
	localparam int DIV_LAT = QB + 2;

	localparam logic [KW-1:0]         K_3_OVER_4PI = 30'd1025347913;
	localparam logic signed [XYW-1:0] CORDIC_START = 33'sd652032874;
	localparam logic signed [RW-1:0]  LIMIT_ZERO   = 32'sd18305282;
	localparam logic signed [RW-1:0]  LIMIT_THREEQ = 32'sd3560236;
	localparam logic signed [TW-1:0]  Q16_THREEQ   = 25'sd49152;
	localparam logic signed [TW-1:0]  Q16_THREE8   = 25'sd24576;
	localparam logic signed [TW-1:0]  Q16_HALF     = 25'sd32768;
	localparam logic signed [48:0]    E_WIDE       = 49'sd2415919104;
	localparam logic signed [48:0]    E_NARROW     = 49'sd603979776;

	// atan(2^-i) in turns, q32
	localparam logic [29:0] ATAN_TURNS [CORDIC_MAX] = '{
		30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43, 30'h0145D7E1,
		30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F, 30'h000A2F98, 30'h000517CC,
		30'h00028BE6, 30'h000145F3, 30'h0000A2FA, 30'h0000517D, 30'h000028BE, 30'h0000145F,
		30'h00000A30, 30'h00000518, 30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051,
		30'h00000029, 30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000003, 30'h00000001,
		30'h00000001, 30'h00000000
	};

	typedef enum logic [1:0] {
		KIND_NORMAL,
		KIND_LIMIT_ZERO,
		KIND_LIMIT_THREEQ,
		KIND_UNDEF
	} mwe_kind_t;

	typedef struct packed {
		logic                  op;
		logic signed [TW-1:0]  t;
		mwe_kind_t             kind;
	} mwe_item_t;

	// residue modulo 3 of a signed 11-bit value, by base-4 digit sums
	function automatic logic [1:0] mod3(input logic signed [10:0] h);
		logic [11:0] v;
		logic [4:0]  s1;
		logic [2:0]  s2;
		logic [2:0]  s3;
		v  = 12'($signed({h[10], h}) + 12'sd1026);
		s1 = 5'(v[1:0]) + 5'(v[3:2]) + 5'(v[5:4]) + 5'(v[7:6]) + 5'(v[9:8]) + 5'(v[11:10]);
		s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
		s3 = 3'(s2[1:0]) + 3'(s2[2]);
		return (s3 >= 3'd3) ? 2'(s3 - 3'd3) : s3[1:0];
	endfunction

endpackage
`default_nettype wire

FILE: hdl/mwe_front.sv
// front end: takes requests, forms the shifted point and classifies special points
`default_nettype none
module mwe_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic                       operation,
	input  wire logic signed [mwe_pkg::PW-1:0] point,
	input  wire logic                       q_full,
	output logic                            busy,
	output logic                            push,
	output mwe_pkg::mwe_item_t              item
);
	import mwe_pkg::*;

	logic                 valid_s1;
	mwe_item_t            item_s1;
	mwe_item_t            item_d;
	logic signed [TW-1:0] t_d;
	logic signed [TW-1:0] at_d;
	logic                 accept;

	always_comb begin
		t_d = operation ? ($signed({point[PW-1], point}) - Q16_HALF)
		                : $signed({point[PW-1], point});
		at_d = t_d[TW-1] ? -t_d : t_d;
		item_d.op   = operation;
		item_d.t    = t_d;
		item_d.kind = KIND_NORMAL;
		if (!operation) begin
			if (t_d == '0)
				item_d.kind = KIND_LIMIT_ZERO;
			else if (t_d == Q16_THREEQ || t_d == -Q16_THREEQ)
				item_d.kind = KIND_LIMIT_THREEQ;
		end else if (t_d == '0 || at_d == Q16_THREEQ || at_d == Q16_THREE8) begin
			item_d.kind = KIND_UNDEF;
		end
	end

	assign busy   = valid_s1 && q_full;
	assign push   = valid_s1 && !q_full;
	assign accept = start && !busy;
	assign item   = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_d;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/mwe_queue.sv
// short request queue between front and back
`default_nettype none
module mwe_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire mwe_pkg::mwe_item_t wr_item,
	input  wire logic          pop,
	output mwe_pkg::mwe_item_t rd_item,
	output logic               full,
	output logic               empty
);
	import mwe_pkg::*;

	localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CntW = $clog2(QUEUE_DEPTH + 1);

	mwe_item_t       mem_q [QUEUE_DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full    = (count_q == CntW'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_item = mem_q[rd_ptr_q];

	function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
		return (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : PtrW'(p + 1'b1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop)      count_q <= CntW'(count_q + 1'b1);
			else if (pop && !push) count_q <= CntW'(count_q - 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop) && !(pop && empty))
		else $error("queue overflow or underflow");

endmodule
`default_nettype wire

FILE: hdl/mwe_cordic.sv
// pipelined rotation cordic, one stage per step, with quadrant folding
`default_nettype none
module mwe_cordic #(
	parameter int CORDIC_STEPS = mwe_pkg::CORDIC_STEPS_DEF
) (
	input  wire logic                           clk,
	input  wire logic [mwe_pkg::AW-1:0]         angle,
	output logic signed [mwe_pkg::XYW-1:0]      cos_out,
	output logic signed [mwe_pkg::XYW-1:0]      sin_out
);
	import mwe_pkg::*;

	localparam int Steps = (CORDIC_STEPS > CORDIC_MAX) ? CORDIC_MAX : CORDIC_STEPS;

	logic signed [XYW-1:0] x_q    [Steps+1];
	logic signed [XYW-1:0] y_q    [Steps+1];
	logic signed [ZW-1:0]  z_q    [Steps+1];
	logic [1:0]            quad_q [Steps+1];
	logic [AW-1:0]         rnd_d;
	logic [1:0]            quad_d;

	assign rnd_d  = angle + 32'h2000_0000;
	assign quad_d = rnd_d[AW-1:AW-2];

	always_ff @(posedge clk) begin
		quad_q[0] <= quad_d;
		x_q[0]    <= CORDIC_START;
		y_q[0]    <= '0;
		z_q[0]    <= ZW'($signed({2'(angle[AW-1:AW-2] - quad_d), angle[AW-3:0]}));
	end

	for (genvar i = 0; i < Steps; i++) begin : g_step
		logic signed [ZW-1:0] atan_c;
		assign atan_c = $signed({{(ZW-30){1'b0}}, ATAN_TURNS[i]});
		always_ff @(posedge clk) begin
			quad_q[i+1] <= quad_q[i];
			if (!z_q[i][ZW-1]) begin
				x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
				y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
				z_q[i+1] <= z_q[i] - atan_c;
			end else begin
				x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
				y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
				z_q[i+1] <= z_q[i] + atan_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (quad_q[Steps])
			2'd0: begin cos_out <= x_q[Steps];  sin_out <= y_q[Steps];  end
			2'd1: begin cos_out <= -y_q[Steps]; sin_out <= x_q[Steps];  end
			2'd2: begin cos_out <= -x_q[Steps]; sin_out <= -y_q[Steps]; end
			default: begin cos_out <= y_q[Steps]; sin_out <= -x_q[Steps]; end
		endcase
	end

endmodule
`default_nettype wire

FILE: hdl/mwe_divider.sv
// pipelined restoring divider, one quotient bit per stage, capped and signed
`default_nettype none
module mwe_divider (
	input  wire logic                          clk,
	input  wire logic [mwe_pkg::NUM_W-1:0]     num,
	input  wire logic [mwe_pkg::DEN_W-1:0]     den,
	input  wire logic                          neg,
	output logic signed [mwe_pkg::QB:0]        quot
);
	import mwe_pkg::*;

	localparam int WW = DEN_W + QB;

	logic [NUM_W-1:0] r_q   [QB+1];
	logic [DEN_W-1:0] d_q   [QB+1];
	logic [QB-1:0]    q_q   [QB+1];
	logic             cap_q [QB+1];
	logic             neg_q [QB+1];
	logic [QB-1:0]    qm_d;

	always_ff @(posedge clk) begin
		r_q[0]   <= num;
		d_q[0]   <= den;
		q_q[0]   <= '0;
		cap_q[0] <= WW'(num) >= {den, {QB{1'b0}}};
		neg_q[0] <= neg;
	end

	for (genvar j = 0; j < QB; j++) begin : g_bit
		localparam int B = QB - 1 - j;
		logic [WW-1:0] dsh;
		logic          ge;
		assign dsh = WW'(d_q[j]) << B;
		assign ge  = WW'(r_q[j]) >= dsh;
		always_ff @(posedge clk) begin
			r_q[j+1]   <= ge ? NUM_W'(WW'(r_q[j]) - dsh) : r_q[j];
			q_q[j+1]   <= q_q[j] | (QB'(ge) << B);
			d_q[j+1]   <= d_q[j];
			cap_q[j+1] <= cap_q[j];
			neg_q[j+1] <= neg_q[j];
		end
	end

	assign qm_d = cap_q[QB] ? {QB{1'b1}} : q_q[QB];

	always_ff @(posedge clk) begin
		quot <= neg_q[QB] ? -$signed({1'b0, qm_d}) : $signed({1'b0, qm_d});
	end

endmodule
`default_nettype wire

FILE: hdl/mwe_back.sv
// back end: phases, cordic lanes, numerators, denominators, quotients, final value
`default_nettype none
module mwe_back #(
	parameter int CORDIC_STEPS = mwe_pkg::CORDIC_STEPS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	input  wire mwe_pkg::mwe_item_t         in_item,
	output logic                            done,
	output logic signed [mwe_pkg::RW-1:0]   result,
	output logic                            undefined
);
	import mwe_pkg::*;

	localparam int Steps     = (CORDIC_STEPS > CORDIC_MAX) ? CORDIC_MAX : CORDIC_STEPS;
	localparam int CordicLat = Steps + 2;
	localparam int Lanes     = 3;

	// phase stages
	logic [1:0]      hm_d  [Lanes];
	logic [AW-1:0]   u_d   [Lanes];
	logic [1:0]      hm_s1 [Lanes];
	logic [AW-1:0]   u_s1  [Lanes];
	logic            v_s1;
	mwe_item_t       it_s1;
	logic [AW-1:0]   ang_d [Lanes];
	logic [AW-1:0]   ang_s2 [Lanes];
	logic            v_s2;
	mwe_item_t       it_s2;

	always_comb begin
		for (int l = 0; l < Lanes; l++) begin
			logic signed [26:0] prod;
			prod    = $signed({{2{in_item.t[TW-1]}}, in_item.t}) <<< l;
			hm_d[l] = mod3(prod[26:16]);
			u_d[l]  = {prod[15:0], 16'h0001} + AW'(hm_d[l]);
		end
	end

	always_comb begin
		for (int l = 0; l < Lanes; l++) begin
			logic [63:0]   mul;
			logic [AW-1:0] base;
			mul  = 64'(u_s1[l]) * 64'h0000_0000_AAAA_AAAB;
			case (hm_s1[l])
				2'd1:    base = 32'h5555_5555;
				2'd2:    base = 32'hAAAA_AAAA;
				default: base = '0;
			endcase
			ang_d[l] = base + AW'(mul >> 33);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		it_s1  <= in_item;
		hm_s1  <= hm_d;
		u_s1   <= u_d;
		it_s2  <= it_s1;
		ang_s2 <= ang_d;
	end

	// cordic lanes: k = 1, 2, 4
	logic signed [XYW-1:0] cos_c [Lanes];
	logic signed [XYW-1:0] sin_c [Lanes];

	for (genvar l = 0; l < Lanes; l++) begin : g_lane
		mwe_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
			.clk     (clk),
			.angle   (ang_s2[l]),
			.cos_out (cos_c[l]),
			.sin_out (sin_c[l])
		);
	end

	logic      cv_q  [CordicLat];
	mwe_item_t cit_q [CordicLat];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CordicLat; i++) cv_q[i] <= 1'b0;
		end else begin
			cv_q[0] <= v_s2;
			for (int i = 1; i < CordicLat; i++) cv_q[i] <= cv_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		cit_q[0] <= it_s2;
		for (int i = 1; i < CordicLat; i++) cit_q[i] <= cit_q[i-1];
	end

	// products
	mwe_item_t             it_c;
	logic signed [XYW-1:0] ca_d;
	logic signed [XYW-1:0] sa_d;
	logic signed [57:0]    pa_s3, pb_s3;
	logic signed [49:0]    tt_s3;
	logic signed [XYW-1:0] sa_s3, sb_s3;
	logic                  v_s3;
	mwe_item_t             it_s3;

	assign it_c = cit_q[CordicLat-1];
	// lane a: scaling uses sin(k=1), cos(k=2); mother uses cos(k=1), -sin(k=2)
	assign ca_d = it_c.op ? cos_c[0] : cos_c[1];
	assign sa_d = it_c.op ? -sin_c[1] : sin_c[0];

	always_ff @(posedge clk) begin
		pa_s3 <= 58'(it_c.t) * 58'(ca_d);
		pb_s3 <= 58'(it_c.t) * 58'(cos_c[2]);
		tt_s3 <= 50'(it_c.t) * 50'(it_c.t);
		sa_s3 <= sa_d;
		sb_s3 <= sin_c[1];
		it_s3 <= it_c;
	end

	// numerators and denominators
	logic signed [61:0] na_s4, nb_s4;
	logic signed [48:0] e1_s4, e2_s4;
	logic               v_s4;
	mwe_item_t          it_s4;

	always_ff @(posedge clk) begin
		na_s4 <= (62'(pa_s3) <<< 2) + (62'(sa_s3) <<< 17) + (62'(sa_s3) <<< 16);
		nb_s4 <= (62'(pb_s3) <<< 3) + (62'(sb_s3) <<< 17) + (62'(sb_s3) <<< 16);
		e1_s4 <= E_WIDE - 49'(tt_s3);
		e2_s4 <= E_NARROW - 49'(tt_s3);
		it_s4 <= it_s3;
	end

	// magnitudes and signs
	logic [NMW-1:0] ma_s5, mb_s5;
	logic [23:0]    mt_s5;
	logic [46:0]    me1_s5, me2_s5;
	logic           nega_s5, negb_s5;
	logic           v_s5;
	mwe_item_t      it_s5;

	always_ff @(posedge clk) begin
		ma_s5   <= na_s4[61] ? NMW'(-na_s4) : NMW'(na_s4);
		mb_s5   <= nb_s4[61] ? NMW'(-nb_s4) : NMW'(nb_s4);
		mt_s5   <= it_s4.t[TW-1] ? 24'(-it_s4.t) : 24'(it_s4.t);
		me1_s5  <= e1_s4[48] ? 47'(-e1_s4) : 47'(e1_s4);
		me2_s5  <= e2_s4[48] ? 47'(-e2_s4) : 47'(e2_s4);
		nega_s5 <= na_s4[61] ^ it_s4.t[TW-1] ^ e1_s4[48];
		negb_s5 <= nb_s4[61] ^ it_s4.t[TW-1] ^ e2_s4[48];
		it_s5   <= it_s4;
	end

	// partial products
	logic [59:0] pnal_s6, pnah_s6, pnbl_s6, pnbh_s6;
	logic [47:0] pdal_s6, pdbl_s6;
	logic [46:0] pdah_s6, pdbh_s6;
	logic        nega_s6, negb_s6;
	logic        v_s6;
	mwe_item_t   it_s6;

	always_ff @(posedge clk) begin
		pnal_s6 <= 60'(ma_s5[29:0]) * 60'(K_3_OVER_4PI);
		pnah_s6 <= 60'(ma_s5[59:30]) * 60'(K_3_OVER_4PI);
		pnbl_s6 <= 60'(mb_s5[29:0]) * 60'(K_3_OVER_4PI);
		pnbh_s6 <= 60'(mb_s5[59:30]) * 60'(K_3_OVER_4PI);
		pdal_s6 <= 48'(mt_s5) * 48'(me1_s5[23:0]);
		pdah_s6 <= 47'(mt_s5) * 47'(me1_s5[46:24]);
		pdbl_s6 <= 48'(mt_s5) * 48'(me2_s5[23:0]);
		pdbh_s6 <= 47'(mt_s5) * 47'(me2_s5[46:24]);
		nega_s6 <= nega_s5;
		negb_s6 <= negb_s5;
		it_s6   <= it_s5;
	end

	// dividend and divisor assembly
	logic [NUM_W-1:0] numa_s7, numb_s7;
	logic [DEN_W-1:0] dena_s7, denb_s7;
	logic             nega_s7, negb_s7;
	logic             v_s7;
	mwe_item_t        it_s7;

	always_ff @(posedge clk) begin
		numa_s7 <= (NUM_W'(pnah_s6) << 30) + NUM_W'(pnal_s6);
		numb_s7 <= (NUM_W'(pnbh_s6) << 30) + NUM_W'(pnbl_s6);
		dena_s7 <= DEN_W'((71'(pdah_s6) << 24) + 71'(pdal_s6)) << 8;
		denb_s7 <= DEN_W'((71'(pdbh_s6) << 24) + 71'(pdbl_s6)) << 10;
		nega_s7 <= nega_s6;
		negb_s7 <= negb_s6;
		it_s7   <= it_s6;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s3 <= cv_q[CordicLat-1];
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// quotients
	logic signed [QB:0] qa_d, qb_d;

	mwe_divider u_div_a (
		.clk  (clk),
		.num  (numa_s7),
		.den  (dena_s7),
		.neg  (nega_s7),
		.quot (qa_d)
	);

	mwe_divider u_div_b (
		.clk  (clk),
		.num  (numb_s7),
		.den  (denb_s7),
		.neg  (negb_s7),
		.quot (qb_d)
	);

	logic      dv_q  [DIV_LAT];
	mwe_item_t dit_q [DIV_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_LAT; i++) dv_q[i] <= 1'b0;
		end else begin
			dv_q[0] <= v_s7;
			for (int i = 1; i < DIV_LAT; i++) dv_q[i] <= dv_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		dit_q[0] <= it_s7;
		for (int i = 1; i < DIV_LAT; i++) dit_q[i] <= dit_q[i-1];
	end

	// final sum, saturation and special points
	mwe_item_t           it_f;
	logic signed [QB+1:0] sum_d;
	logic signed [RW-1:0] sat_d;
	logic signed [RW-1:0] res_d;
	logic                 und_d;

	assign it_f = dit_q[DIV_LAT-1];

	always_comb begin
		sum_d = it_f.op ? ((QB+2)'(qa_d) + (QB+2)'(qb_d)) : (QB+2)'(qa_d);
		if (sum_d > (QB+2)'(33'sd2147483647))
			sat_d = 32'sh7FFF_FFFF;
		else if (sum_d < -(QB+2)'(33'sd2147483648))
			sat_d = 32'sh8000_0000;
		else
			sat_d = sum_d[RW-1:0];
		und_d = 1'b0;
		case (it_f.kind)
			KIND_LIMIT_ZERO:   res_d = LIMIT_ZERO;
			KIND_LIMIT_THREEQ: res_d = LIMIT_THREEQ;
			KIND_UNDEF: begin
				res_d = '0;
				und_d = 1'b1;
			end
			default:           res_d = sat_d;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dv_q[DIV_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		result    <= res_d;
		undefined <= und_d;
	end

endmodule
`default_nettype wire

FILE: hdl/meyer_wavelet_evaluator.sv
// top level of the meyer wavelet evaluator
//
//  channel   | signals                     | handshake
//  ----------+-----------------------------+------------------------------
//  request   | operation, point            | start high while busy low
//  result    | result, undefined           | done high for one cycle
//
// one request per cycle is taken, without pause, for any stream of points
// the path from the accepting edge to the done pulse runs through the cordic stages
// (one per step) and the 34 divider bit stages, among other registers
// reset (arst_n low) empties the queue and clears every valid flag at once
// the result side never stalls, so the queue never fills and busy stays low
`default_nettype none
module meyer_wavelet_evaluator #(
	parameter int CORDIC_STEPS = mwe_pkg::CORDIC_STEPS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          operation,
	input  wire logic signed [mwe_pkg::PW-1:0] point,
	output logic                               done,
	output logic signed [mwe_pkg::RW-1:0]      result,
	output logic                               undefined
);
	import mwe_pkg::*;

	// front to queue
	logic      push;
	mwe_item_t front_item;
	// queue to back
	logic      q_full;
	logic      q_empty;
	logic      pop;
	mwe_item_t back_item;

	// front: registers the request and tags special points
	mwe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.point     (point),
		.q_full    (q_full),
		.busy      (busy),
		.push      (push),
		.item      (front_item)
	);

	// decoupling queue
	mwe_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (front_item),
		.pop     (pop),
		.rd_item (back_item),
		.full    (q_full),
		.empty   (q_empty)
	);

	// the back pipeline takes a request every cycle
	assign pop = !q_empty;

	// back: phases, sine and cosine, quotients and saturation
	mwe_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pop),
		.in_item   (back_item),
		.done      (done),
		.result    (result),
		.undefined (undefined)
	);

	// the back never stalls, so the front must never hold off a request
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("front held off a request");

	// an undefined point always reports a zero value
	a_undef_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && undefined |-> result == '0)
		else $error("undefined result carries a nonzero value");

endmodule
`default_nettype wire
